// ----- rtl/core/kqt_pkg.sv -----
// ----------------------------------------------------------------------------
// Keyed quantity table package
// Shared widths, codes and the per-cell control word.
// ----------------------------------------------------------------------------
package kqt_pkg;

  localparam int unsigned DefTableDepth = 16;

  localparam int unsigned ModeW   = 2;
  localparam int unsigned KeyW    = 64;
  localparam int unsigned AmountW = 16;
  localparam int unsigned QtyW    = 32;

  typedef logic [KeyW-1:0]    key_t;
  typedef logic [QtyW-1:0]    qty_t;
  typedef logic [AmountW-1:0] amount_t;
  typedef logic [ModeW-1:0]   mode_t;

  localparam mode_t ModeAdd    = 2'd0;
  localparam mode_t ModeRemove = 2'd1;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusFull     = 2'd1,
    StatusShort    = 2'd2,
    StatusNotFound = 2'd3
  } status_e;

  // Control word handed from the sequencer to each cell.
  typedef struct packed {
    logic vld;    // cell lies below the fill count
    logic load;   // take key and quantity from the broadcast bus
    logic shift;  // take key and quantity from the upper neighbour
  } cell_ctl_t;

endpackage

// ----- rtl/core/kqt_cell.sv -----
// ----------------------------------------------------------------------------
// Keyed quantity table cell
// One table slot: holds a key and its quantity, compares the key against the
// request, and either loads from the broadcast bus or from its upper
// neighbour when the table is compacted.
// ----------------------------------------------------------------------------
module kqt_cell (
  input  logic              clk_i,
  input  kqt_pkg::cell_ctl_t ctl_i,
  input  kqt_pkg::key_t     req_key_i,
  input  kqt_pkg::qty_t     bus_qty_i,
  input  kqt_pkg::key_t     nxt_key_i,
  input  kqt_pkg::qty_t     nxt_qty_i,
  output kqt_pkg::key_t     key_o,
  output kqt_pkg::qty_t     qty_o,
  output logic              hit_o
);
  import kqt_pkg::*;

  key_t key_q, key_d;
  qty_t qty_q, qty_d;

  always_comb begin
    key_d = key_q;
    qty_d = qty_q;
    if (ctl_i.shift) begin
      key_d = nxt_key_i;
      qty_d = nxt_qty_i;
    end else if (ctl_i.load) begin
      key_d = req_key_i;
      qty_d = bus_qty_i;
    end
  end

  // Slot contents carry no reset; the fill count decides what is valid.
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    qty_q <= qty_d;
  end

  assign key_o = key_q;
  assign qty_o = qty_q;
  assign hit_o = ctl_i.vld && (key_q == req_key_i);

endmodule

// ----- rtl/core/keyed_quantity_table.sv -----
// ----------------------------------------------------------------------------
// Keyed quantity table
// Associative key to quantity table held in a row of cells, kept compact in
// insertion order. Add, remove and query requests give one result word each.
// ----------------------------------------------------------------------------
//  Channel   Direction  Fields (lowest bit first)
//  s_axis    in         tuser: mode; tdata: item_key, amount
//  m_axis    out        tdata: success, status, quantity, zero fill
//
//  A request passes through accept, a lookup step in which every cell
//  compares its key, and an update step that writes the cells and loads the
//  result register. The update step waits while the result register is full
//  and not taken. Reset empties the table at once. One request is in work at
//  a time; a new word is taken as soon as the previous one reaches the
//  result register.
// ----------------------------------------------------------------------------
module keyed_quantity_table #(
  parameter int unsigned TableDepth = kqt_pkg::DefTableDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // item_key[63:0], amount[79:64]
  input  logic [1:0]  s_axis_tuser,   // mode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // success[0], status[2:1], quantity[34:3]
);
  import kqt_pkg::*;

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  typedef enum logic [1:0] {
    StIdle,
    StLookup,
    StExec
  } state_e;

  state_e            state_q;
  logic [CntW-1:0]   count_q, count_d;

  mode_t             mode_q;
  key_t              key_q;
  amount_t           amt_q;

  logic              hit_any_q;
  logic [IdxW-1:0]   slot_q;
  qty_t              cur_qty_q;

  logic              out_vld_q;
  logic              out_succ_q, out_succ_d;
  status_e           out_stat_q, out_stat_d;
  qty_t              out_qty_q, out_qty_d;

  cell_ctl_t         ctl   [TableDepth];
  key_t              ckey  [TableDepth];
  qty_t              cqty  [TableDepth];
  logic [TableDepth-1:0] hit;

  logic              fire;
  logic              wr_hit, append, delete;
  qty_t              bus_qty;
  logic              hit_any_d;
  logic [IdxW-1:0]   slot_d;
  qty_t              cur_qty_d;
  logic [QtyW:0]     sum;
  qty_t              sat, diff, amt_ext;

  assign s_axis_tready = (state_q == StIdle);
  assign fire          = (state_q == StExec) && (!out_vld_q || m_axis_tready);

  // Lookup: fold the one-hot hit vector into a slot number and a quantity.
  always_comb begin
    hit_any_d = 1'b0;
    slot_d    = '0;
    cur_qty_d = '0;
    for (int unsigned j = 0; j < TableDepth; j++) begin
      hit_any_d = hit_any_d | hit[j];
      slot_d    = slot_d | (hit[j] ? IdxW'(j) : '0);
      cur_qty_d = cur_qty_d | (hit[j] ? cqty[j] : '0);
    end
  end

  // Update: work out the outcome and which cells change.
  always_comb begin
    amt_ext    = QtyW'(amt_q);
    sum        = {1'b0, cur_qty_q} + {1'b0, amt_ext};
    sat        = sum[QtyW] ? '1 : sum[QtyW-1:0];
    diff       = cur_qty_q - amt_ext;
    wr_hit     = 1'b0;
    append     = 1'b0;
    delete     = 1'b0;
    bus_qty    = '0;
    count_d    = count_q;
    out_succ_d = 1'b1;
    out_stat_d = StatusOk;
    out_qty_d  = '0;
    case (mode_q)
      ModeAdd: begin
        if (hit_any_q) begin
          wr_hit    = 1'b1;
          bus_qty   = sat;
          out_qty_d = sat;
        end else if (count_q < CntW'(TableDepth)) begin
          append    = 1'b1;
          bus_qty   = amt_ext;
          out_qty_d = amt_ext;
          count_d   = count_q + 1'b1;
        end else begin
          out_succ_d = 1'b0;
          out_stat_d = StatusFull;
        end
      end
      ModeRemove: begin
        if (!hit_any_q) begin
          out_succ_d = 1'b0;
          out_stat_d = StatusNotFound;
        end else if (cur_qty_q < amt_ext) begin
          out_succ_d = 1'b0;
          out_stat_d = StatusShort;
          out_qty_d  = cur_qty_q;
        end else if (diff == '0) begin
          delete  = 1'b1;
          count_d = count_q - 1'b1;
        end else begin
          wr_hit    = 1'b1;
          bus_qty   = diff;
          out_qty_d = diff;
        end
      end
      default: begin
        out_qty_d = hit_any_q ? cur_qty_q : '0;
      end
    endcase
  end

  for (genvar j = 0; j < TableDepth; j++) begin : g_cell
    key_t nxt_key;
    qty_t nxt_qty;

    if (j + 1 < TableDepth) begin : g_mid
      assign nxt_key = ckey[j+1];
      assign nxt_qty = cqty[j+1];
    end else begin : g_top
      // The top slot falls out of range after a delete; its contents are dead.
      assign nxt_key = ckey[j];
      assign nxt_qty = cqty[j];
    end

    assign ctl[j].vld   = (CntW'(j) < count_q);
    assign ctl[j].load  = fire && ((wr_hit && (IdxW'(j) == slot_q)) ||
                                   (append && (CntW'(j) == count_q)));
    assign ctl[j].shift = fire && delete && (IdxW'(j) >= slot_q);

    kqt_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl[j]),
      .req_key_i (key_q),
      .bus_qty_i (bus_qty),
      .nxt_key_i (nxt_key),
      .nxt_qty_i (nxt_qty),
      .key_o     (ckey[j]),
      .qty_o     (cqty[j]),
      .hit_o     (hit[j])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (s_axis_tvalid) begin
            state_q <= StLookup;
          end
        end
        StLookup: begin
          state_q <= StExec;
        end
        StExec: begin
          if (fire) begin
            state_q   <= StIdle;
            count_q   <= count_d;
            out_vld_q <= 1'b1;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      mode_q <= s_axis_tuser;
      key_q  <= s_axis_tdata[63:0];
      amt_q  <= s_axis_tdata[79:64];
    end
    if (state_q == StLookup) begin
      hit_any_q <= hit_any_d;
      slot_q    <= slot_d;
      cur_qty_q <= cur_qty_d;
    end
    if (fire) begin
      out_succ_q <= out_succ_d;
      out_stat_q <= out_stat_d;
      out_qty_q  <= out_qty_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'b0, out_qty_q, out_stat_q, out_succ_q};

  // Keys in the valid part of the table are distinct.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLookup) |-> $onehot0(hit))
    else $error("more than one cell matched the key");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TableDepth))
    else $error("fill count beyond table depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(count_q))
    else $error("fill count changed outside an update");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == StExec))
    else $error("result word raised without an update");

endmodule

// ----- dv/kqt_table_checker.sv -----
// ----------------------------------------------------------------------------
// Keyed quantity table checker
// Watches both stream channels. Each accepted request word is applied to a
// private copy of the table, and the reply that it should give is queued.
// Each result word is compared field by field with the oldest queued reply.
// ----------------------------------------------------------------------------
module kqt_table_checker #(
  parameter int unsigned TableDepth = kqt_pkg::DefTableDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // item_key[63:0], amount[79:64]
  input  logic [1:0]  s_axis_tuser,   // mode[1:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // success[0], status[2:1], quantity[34:3]
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned status_seen_o [4],
  output int unsigned peak_fill_o
);
  import kqt_pkg::*;

  localparam int unsigned MaxPrinted = 50;

  typedef struct packed {
    logic    success;
    status_e status;
    qty_t    qty;
  } table_reply_t;

  key_t        stock_keys [TableDepth];
  qty_t        stock_qty  [TableDepth];
  int unsigned stock_fill;

  table_reply_t expected_replies [$];

  task automatic report_mismatch(input string what);
    if (fail_count_o < MaxPrinted) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    fail_count_o++;
  endtask

  // Applies one request to the table copy and returns the reply it gives.
  function automatic table_reply_t apply_request(input mode_t mode, input key_t key,
                                                 input amount_t amount);
    table_reply_t     reply;
    int unsigned      slot;
    logic [QtyW:0]    sum;
    slot  = TableDepth;
    for (int unsigned i = 0; i < stock_fill; i++) begin
      if (slot == TableDepth && stock_keys[i] == key) slot = i;
    end
    reply = '{success: 1'b1, status: StatusOk, qty: '0};
    case (mode)
      ModeAdd: begin
        if (slot < TableDepth) begin
          sum = stock_qty[slot] + amount;
          stock_qty[slot] = sum[QtyW] ? '1 : sum[QtyW-1:0];
          reply.qty = stock_qty[slot];
        end else if (stock_fill < TableDepth) begin
          stock_keys[stock_fill] = key;
          stock_qty[stock_fill]  = qty_t'(amount);
          stock_fill++;
          reply.qty = qty_t'(amount);
        end else begin
          reply.success = 1'b0;
          reply.status  = StatusFull;
        end
      end
      ModeRemove: begin
        if (slot == TableDepth) begin
          reply.success = 1'b0;
          reply.status  = StatusNotFound;
        end else if (stock_qty[slot] < qty_t'(amount)) begin
          reply.success = 1'b0;
          reply.status  = StatusShort;
          reply.qty     = stock_qty[slot];
        end else begin
          stock_qty[slot] = stock_qty[slot] - qty_t'(amount);
          reply.qty = stock_qty[slot];
          // An emptied entry is dropped and the later entries close the gap.
          if (stock_qty[slot] == '0) begin
            for (int unsigned j = slot; j + 1 < stock_fill; j++) begin
              stock_keys[j] = stock_keys[j+1];
              stock_qty[j]  = stock_qty[j+1];
            end
            stock_fill--;
          end
        end
      end
      default: begin
        if (slot < TableDepth) reply.qty = stock_qty[slot];
      end
    endcase
    return reply;
  endfunction

  task automatic check_reply(input logic [39:0] word);
    table_reply_t want;
    if (expected_replies.size() == 0) begin
      report_mismatch($sformatf("result word %h arrived with no request waiting", word));
      return;
    end
    want = expected_replies.pop_front();
    if (word[0] !== want.success) begin
      report_mismatch($sformatf("success %b, expected %b", word[0], want.success));
    end
    if (word[2:1] !== want.status) begin
      report_mismatch($sformatf("status %0d, expected %s", word[2:1], want.status.name()));
    end
    if (word[34:3] !== want.qty) begin
      report_mismatch($sformatf("quantity %h, expected %h", word[34:3], want.qty));
    end
    if (word[39:35] !== '0) begin
      report_mismatch($sformatf("fill bits %b are not zero", word[39:35]));
    end
    status_seen_o[int'(want.status)]++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stock_fill = 0;
      expected_replies.delete();
    end else begin
      // A result word can never belong to a request taken at the same edge.
      if (m_axis_tvalid && m_axis_tready) check_reply(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) begin
        expected_replies.push_back(apply_request(s_axis_tuser, s_axis_tdata[63:0],
                                                 s_axis_tdata[79:64]));
        if (stock_fill > peak_fill_o) peak_fill_o = stock_fill;
      end
    end
    pending_o = expected_replies.size();
  end

endmodule

// ----- dv/tb_keyed_quantity_table.sv -----
// ----------------------------------------------------------------------------
// Keyed quantity table testbench
// Drives request words into the table and gives the verdict. A directed
// opening covers empty, full, short, not found, zero amounts, the spare mode
// code and compaction; a short full-rate burst of large adds hits one entry;
// random traffic with add, query and remove round trips follows. Both sides
// idle at random, and the receiver once holds off long enough to stall the
// input.
// ----------------------------------------------------------------------------
module tb_keyed_quantity_table;
  import kqt_pkg::*;

  localparam int unsigned TableDepth     = DefTableDepth;
  localparam int unsigned PoolSize       = 24;
  localparam int unsigned RandomItems    = 640;
  localparam int unsigned BurstAdds      = 40;
  localparam int unsigned HoldCycles     = 120;
  localparam int unsigned DrainCycles    = 20;
  localparam int unsigned CycleLimit     = 50000;

  // The block treats the spare mode code as a query.
  localparam mode_t ModeQuery = 2'd2;
  localparam mode_t ModeSpare = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;   // item_key[63:0], amount[79:64]
  logic [1:0]  s_axis_tuser;   // mode[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // success[0], status[2:1], quantity[34:3]

  int unsigned fail_count;
  int unsigned pending;
  int unsigned status_seen [4];
  int unsigned peak_fill;

  int unsigned sent_by_mode [4];
  int unsigned cycle_count;
  bit          steady;
  bit          random_started;
  logic        hold_rx;
  key_t        key_pool [PoolSize];

  keyed_quantity_table #(
    .TableDepth(TableDepth)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  kqt_table_checker #(
    .TableDepth(TableDepth)
  ) i_checker (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .status_seen_o (status_seen),
    .peak_fill_o   (peak_fill)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Receiver: random back-pressure, none while steady, and never ready while held.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      m_axis_tready <= !hold_rx && (steady || $urandom_range(99) >= 18);
    end
  end

  initial begin
    hold_rx <= 1'b0;
    wait (random_started);
    repeat (20) @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles with %0d results outstanding.",
             cycle_count, pending);
    $display("Some tests failed");
    $finish;
  end

  // Offers one request word, after a random gap unless steady, and waits until it is taken.
  task automatic push_request(input mode_t mode, input key_t key, input amount_t amount);
    while (!steady && $urandom_range(99) < 18) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {amount, key};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_by_mode[int'(mode)]++;
  endtask

  // Mostly small amounts so that removes often empty an entry.
  function automatic amount_t pick_amount();
    return ($urandom_range(9) == 0) ? amount_t'($urandom) : amount_t'($urandom_range(7));
  endfunction

  initial begin
    key_t        key;
    key_t        sprocket;
    amount_t     amount;
    int unsigned pick;
    int unsigned n_random;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= '0;
    s_axis_tdata  <= '0;
    sprocket = "SPROCKET";
    key_pool[0] = "BOLT";
    key_pool[1] = "NUT";
    key_pool[2] = "WASHER";
    key_pool[3] = "HINGE";
    key_pool[4] = "RIVET";
    key_pool[5] = "SPRING";
    key_pool[6] = "GASKET";
    key_pool[7] = "BEARINGS";
    for (int unsigned i = 8; i < PoolSize; i++) key_pool[i] = {$urandom, $urandom};

    wait (rst_ni);
    @(posedge clk_i);

    // Empty table, zero amounts, a short remove and the spare mode code.
    push_request(ModeQuery, '0, '0);
    push_request(ModeRemove, '1, '1);
    push_request(ModeAdd, '0, '0);
    push_request(ModeRemove, '0, '0);
    push_request(ModeAdd, '1, '1);
    push_request(ModeAdd, sprocket, 16'd5);
    push_request(ModeRemove, sprocket, 16'd6);
    push_request(ModeSpare, '1, '1);
    // Fill to the top, overflow, then empty an early entry so the rest shift.
    for (int unsigned i = 0; i < TableDepth - 2; i++) begin
      push_request(ModeAdd, key_pool[i], amount_t'(i + 1));
    end
    push_request(ModeAdd, key_pool[TableDepth-2], 16'd1);
    push_request(ModeAdd, '1, '1);
    push_request(ModeRemove, sprocket, 16'd5);
    push_request(ModeQuery, key_pool[TableDepth-3], '0);
    push_request(ModeAdd, key_pool[TableDepth-2], '0);

    // Full-rate burst of large adds on one entry.
    steady = 1'b1;
    for (int unsigned i = 0; i < BurstAdds; i++) push_request(ModeAdd, '1, '1);
    push_request(ModeRemove, '1, '1);
    push_request(ModeAdd, '1, '1);
    push_request(ModeAdd, '1, '1);
    push_request(ModeQuery, '1, '0);
    steady = 1'b0;

    random_started = 1'b1;
    n_random = 0;
    while (n_random < RandomItems) begin
      steady = (n_random >= 300 && n_random < 420);
      pick   = $urandom_range(99);
      key    = ($urandom_range(29) == 0) ? key_t'({$urandom, $urandom})
                                         : key_pool[$urandom_range(PoolSize - 1)];
      amount = pick_amount();
      if (pick < 30) begin
        push_request(ModeAdd, key, amount);
        push_request(ModeQuery, key, amount_t'($urandom));
        push_request(ModeRemove, key, amount);
        n_random += 3;
      end else begin
        if (pick < 52) push_request(ModeAdd, key, amount);
        else if (pick < 76) push_request(ModeRemove, key, amount);
        else if (pick < 94) push_request(ModeQuery, key, amount);
        else push_request(ModeSpare, key, amount);
        n_random++;
      end
    end
    s_axis_tvalid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d adds, %0d removes, %0d queries, %0d spare-code words,",
             sent_by_mode[0], sent_by_mode[1], sent_by_mode[2], sent_by_mode[3]);
    $display("  replies ok/full/short/absent %0d/%0d/%0d/%0d, peak fill %0d of %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             peak_fill, TableDepth);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
